[hw/rtl/dlf_pkg.sv]
// Shared types and constants of the dense layer forward block.
package dlf_pkg;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned ACC_W     = 40;
  localparam int unsigned ROW_IDX_W = 4;
  localparam int unsigned COL_IDX_W = 6;
  localparam int unsigned ROWS_W    = 5;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic signed [DATA_W:0] SAT_MAX = (DATA_W+1)'(32767);
  localparam logic signed [DATA_W:0] SAT_MIN = -(DATA_W+1)'(32768);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELU_ENABLE = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD_WEIGHT = 2'd0,
    OP_LOAD_BIAS   = 2'd1,
    OP_ELEMENT     = 2'd2
  } dlf_op_e;

endpackage

[hw/rtl/dlf_ram.sv]
// Simple dual-port synchronous RAM with registered read data.
module dlf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/dlf_mac.sv]
// Two-stage multiply-accumulate path that writes back to the accumulator memory.
module dlf_mac import dlf_pkg::*; #(
  parameter int unsigned RW = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s1_vld_i,
  input  logic [RW-1:0]            s1_row_i,
  input  logic signed [DATA_W-1:0] weight_i,
  input  logic signed [DATA_W-1:0] x_i,
  input  logic signed [ACC_W-1:0]  acc_i,
  output logic                     busy_o,
  output logic                     wr_en_o,
  output logic [RW-1:0]            wr_row_o,
  output logic [ACC_W-1:0]         wr_data_o
);

  logic                     s2_vld_q;
  logic [RW-1:0]            s2_row_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_i) begin
      s2_row_q <= s1_row_i;
      prod_q   <= weight_i * x_i;
      acc_q    <= acc_i;
    end
  end

  // The sum wraps within the accumulator width.
  assign wr_data_o = acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign wr_en_o   = s2_vld_q;
  assign wr_row_o  = s2_row_q;
  assign busy_o    = s2_vld_q;

endmodule

[hw/rtl/dlf_post.sv]
// Output stage math: scale down, add bias, saturate and, when enabled, rectify.
module dlf_post import dlf_pkg::*; #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic signed [ACC_W-1:0]  acc_i,
  input  logic signed [DATA_W-1:0] bias_i,
  input  logic                     relu_i,
  output logic [DATA_W-1:0]        value_o
);

  logic signed [ACC_W-1:0] scaled;
  logic signed [ACC_W:0]   sum;
  logic signed [DATA_W:0]  sat;

  always_comb begin
    // Arithmetic shift rounds toward minus infinity.
    scaled = acc_i >>> FRAC_BITS;
    sum    = {scaled[ACC_W-1], scaled} + (ACC_W+1)'(bias_i);
    if (sum > (ACC_W+1)'(SAT_MAX)) begin
      sat = SAT_MAX;
    end else if (sum < (ACC_W+1)'(SAT_MIN)) begin
      sat = SAT_MIN;
    end else begin
      sat = sum[DATA_W:0];
    end
    if (relu_i && sat[DATA_W]) begin
      value_o = '0;
    end else begin
      value_o = sat[DATA_W-1:0];
    end
  end

endmodule

[hw/rtl/dense_layer_forward.sv]
// Top level of the dense layer forward block: control sequencer, memories and ports.
//
//  Channel  Direction  Handshake               Payload
//  s_axis   in         s_axis_tvalid/tready    tuser operation, tdata row/col/data, tlast
//  m_axis   out        m_axis_tvalid/tready    tdata row/value, tlast
//  cfg      in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// A weight or bias load is written directly into its memory. A vector element passes
// through the accepting cycle, one accumulator memory access per neuron in use through
// the single shared multiplier, and then a drain of the pipeline. The word marked last
// adds a result pass over each neuron in use, longer if the output side stalls. Reset
// clears all accumulators at once through per-row valid bits; weights and biases are not
// cleared. A full output register stalls only the result pass; a new word is accepted
// while the last result still waits.
module dense_layer_forward import dlf_pkg::*; #(
  parameter int unsigned MAX_ROWS  = 16,
  parameter int unsigned MAX_COLS  = 64,
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input words.
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [3:0] row_index, [9:4] col_index, [25:10] data_value, [31:26] zero
  input  logic [31:0]          s_axis_tdata_i,
  // [1:0] operation
  input  logic [1:0]           s_axis_tuser_i,
  input  logic                 s_axis_tlast_i,
  // Result words.
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [3:0] out_row, [19:4] out_value, [23:20] zero
  output logic [23:0]          m_axis_tdata_o,
  output logic                 m_axis_tlast_o,
  // Configuration writes.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ROWS_W-1:0]    cfg_data_i
);

  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW = $clog2(MAX_ROWS + 1);
  localparam int unsigned WDEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ACC   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_ERD   = 3'd3;
  localparam logic [2:0] ST_EOUT  = 3'd4;

  // Unpack the input word.
  logic [ROW_IDX_W-1:0]     in_row;
  logic [COL_IDX_W-1:0]     in_col;
  logic signed [DATA_W-1:0] in_data;
  logic                     in_acc;
  logic                     row_ok;
  logic                     col_ok;

  assign in_row  = s_axis_tdata_i[3:0];
  assign in_col  = s_axis_tdata_i[9:4];
  assign in_data = s_axis_tdata_i[25:10];
  assign row_ok  = 32'(in_row) < MAX_ROWS;
  assign col_ok  = 32'(in_col) < MAX_COLS;
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;

  // Configuration registers; writes are always taken.
  logic [ROWS_W-1:0] rows_q;
  logic              relu_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_W'(16);
      relu_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ROWS_IN_USE: rows_q <= cfg_data_i;
        CFG_RELU_ENABLE: relu_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Number of neurons in use, clamped to the supported range.
  logic [CW-1:0] n_rows;

  always_comb begin
    if (rows_q == '0) begin
      n_rows = CW'(1);
    end else if (32'(rows_q) > MAX_ROWS) begin
      n_rows = CW'(MAX_ROWS);
    end else begin
      n_rows = CW'(rows_q);
    end
  end

  // Sequencer state.
  logic [2:0]               state_q, state_d;
  logic [CW-1:0]            r_q, r_d;
  logic [AW-1:0]            wa_q, wa_d;
  logic signed [DATA_W-1:0] x_q, x_d;
  logic                     last_q, last_d;
  logic                     s1_vld_q;
  logic [RW-1:0]            s1_row_q;
  logic                     row_is_last;

  // Memory ports.
  logic                     w_we;
  logic [AW-1:0]            w_waddr;
  logic [AW-1:0]            w_raddr;
  logic                     w_re;
  logic [DATA_W-1:0]        w_rdata;
  logic                     b_we;
  logic                     b_re;
  logic [DATA_W-1:0]        b_rdata;
  logic                     a_re;
  logic [RW-1:0]            a_raddr;
  logic [ACC_W-1:0]         a_rdata;
  logic signed [ACC_W-1:0]  a_value;
  logic                     a_ok_q;
  logic [MAX_ROWS-1:0]      a_vld_q, a_vld_d;

  // Multiply-accumulate path.
  logic                     mac_busy;
  logic                     mac_we;
  logic [RW-1:0]            mac_row;
  logic [ACC_W-1:0]         mac_data;

  // Output register.
  logic                     m_vld_q, m_vld_d;
  logic [ROW_IDX_W-1:0]     m_row_q;
  logic [DATA_W-1:0]        m_val_q;
  logic                     m_last_q;
  logic [DATA_W-1:0]        post_val;
  logic                     out_load;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign row_is_last     = ((r_q + CW'(1)) == n_rows);

  assign w_we    = in_acc && (s_axis_tuser_i == OP_LOAD_WEIGHT) && row_ok && col_ok;
  assign w_waddr = AW'(in_row) * AW'(MAX_COLS) + AW'(in_col);
  assign w_re    = (state_q == ST_ACC);
  assign w_raddr = wa_q;
  assign b_we    = in_acc && (s_axis_tuser_i == OP_LOAD_BIAS) && row_ok;
  assign b_re    = (state_q == ST_ERD);
  assign a_re    = (state_q == ST_ACC) || (state_q == ST_ERD);
  assign a_raddr = r_q[RW-1:0];

  // An accumulator row not written since the last clear reads as zero.
  assign a_value = a_ok_q ? a_rdata : '0;

  assign out_load = (state_q == ST_EOUT) && (!m_vld_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    wa_d    = wa_q;
    x_d     = x_q;
    last_d  = last_q;
    a_vld_d = a_vld_q;
    if (mac_we) begin
      a_vld_d[mac_row] = 1'b1;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_axis_tuser_i == OP_ELEMENT)) begin
          r_d    = '0;
          x_d    = in_data;
          wa_d   = AW'(in_col);
          last_d = s_axis_tlast_i;
          if (col_ok) begin
            state_d = ST_ACC;
          end else if (s_axis_tlast_i) begin
            state_d = ST_ERD;
          end
        end
      end
      ST_ACC: begin
        r_d  = r_q + CW'(1);
        wa_d = wa_q + AW'(MAX_COLS);
        if (row_is_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_q && !mac_busy) begin
          r_d     = '0;
          state_d = last_q ? ST_ERD : ST_IDLE;
        end
      end
      ST_ERD: begin
        state_d = ST_EOUT;
      end
      ST_EOUT: begin
        if (out_load) begin
          if (row_is_last) begin
            // Every row has been read out: clear the accumulators.
            a_vld_d = '0;
            state_d = ST_IDLE;
          end else begin
            r_d     = r_q + CW'(1);
            state_d = ST_ERD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_vld_d = m_vld_q;
    if (out_load) begin
      m_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      r_q      <= '0;
      last_q   <= 1'b0;
      s1_vld_q <= 1'b0;
      a_vld_q  <= '0;
      m_vld_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      r_q      <= r_d;
      last_q   <= last_d;
      s1_vld_q <= (state_q == ST_ACC);
      a_vld_q  <= a_vld_d;
      m_vld_q  <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q <= wa_d;
    x_q  <= x_d;
    if (state_q == ST_ACC) begin
      s1_row_q <= r_q[RW-1:0];
    end
    if (a_re) begin
      a_ok_q <= a_vld_q[a_raddr];
    end
    if (out_load) begin
      m_row_q  <= ROW_IDX_W'(r_q);
      m_val_q  <= post_val;
      m_last_q <= row_is_last;
    end
  end

  dlf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WDEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (in_data),
    .re_i    (w_re),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  dlf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ROWS)
  ) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (RW'(in_row)),
    .wdata_i (in_data),
    .re_i    (b_re),
    .raddr_i (r_q[RW-1:0]),
    .rdata_o (b_rdata)
  );

  dlf_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_ROWS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (mac_we),
    .waddr_i (mac_row),
    .wdata_i (mac_data),
    .re_i    (a_re),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  dlf_mac #(
    .RW (RW)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s1_vld_i  (s1_vld_q),
    .s1_row_i  (s1_row_q),
    .weight_i  (w_rdata),
    .x_i       (x_q),
    .acc_i     (a_value),
    .busy_o    (mac_busy),
    .wr_en_o   (mac_we),
    .wr_row_o  (mac_row),
    .wr_data_o (mac_data)
  );

  dlf_post #(
    .FRAC_BITS (FRAC_BITS)
  ) u_post (
    .acc_i   (a_value),
    .bias_i  (b_rdata),
    .relu_i  (relu_q),
    .value_o (post_val)
  );

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = {4'b0, m_val_q, m_row_q};
  assign m_axis_tlast_o  = m_last_q;

  // A new word is only taken once the accumulate pipeline is empty.
  a_ready_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (!s1_vld_q && !mac_busy))
    else $error("input accepted while accumulate pipeline busy");

  // A write-back never hits the row being read in the same cycle.
  a_no_same_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mac_we && a_re) |-> (mac_row != a_raddr))
    else $error("accumulator read and write collide");

  // The result pass starts with the pipeline drained.
  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ERD) |-> !mac_busy)
    else $error("result pass overlaps accumulation");

endmodule
